// ----- rtl/core/c3cg_pkg.sv -----
package c3cg_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int COL_W      = PROD_W + 2;
    localparam int SUM_W      = COL_W + 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2    = 3'd4;

    localparam logic [WIDTH_W-1:0]    RST_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0]   RST_HEIGHT = 16'd480;
    localparam logic [CFG_DATA_W-1:0] RST_ROW0   = 48'h0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW1   = 48'h0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW2   = 48'h0000_0000_0000;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic [COEF_W-1:0]        t_coef;
    typedef t_pix  [2:0]              t_col;
    typedef t_coef [2:0]              t_coef_col;
    typedef logic signed [COL_W-1:0]  t_col_sum;

    typedef struct packed {
        logic shift;
        logic advance;
    } t_cell_ctl;

endpackage

// ----- rtl/core/c3cg_ram.sv -----
module c3cg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/c3cg_cell.sv -----
module c3cg_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  c3cg_pkg::t_cell_ctl    i_ctl,
    input  c3cg_pkg::t_col         i_pix,
    input  c3cg_pkg::t_coef_col    i_coef,
    output c3cg_pkg::t_col         o_pix,
    output c3cg_pkg::t_col_sum     o_col_sum
);
    import c3cg_pkg::*;

    t_col                     r_pix;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] n_prod [3];
    t_col_sum                 r_sum;
    t_col_sum                 n_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = PROD_W'($signed(i_coef[k])) * PROD_W'($signed({1'b0, r_pix[k]}));
        end
        n_sum = COL_W'(r_prod[0]) + COL_W'(r_prod[1]) + COL_W'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_ctl.shift) begin
            r_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_sum <= n_sum;
        end
    end

    assign o_pix     = r_pix;
    assign o_col_sum = r_sum;
endmodule

// ----- rtl/core/conv3x3_clamped_gray_unit.sv -----
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] pixel
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata[7:0] filtered, tlast last_of_frame
// cfg       | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data[47:0]
//
// one pixel per clock while the output is not stalled; a result is registered in turn through
// the line buffer read, the window cells and their two product/sum stages, then the output register
// synchronous active-low reset clears counters, window cell pixels and valid flags
// line buffers are not cleared; config is always ready
// a stalled output fills a skid register, then the whole pipeline holds
module conv3x3_clamped_gray_unit #(
    parameter int MAX_WIDTH = c3cg_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] filtered
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [c3cg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [c3cg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import c3cg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // config registers
    logic [WIDTH_W-1:0]    r_width;
    logic [HEIGHT_W-1:0]   r_height;
    logic [CFG_DATA_W-1:0] r_row0;
    logic [CFG_DATA_W-1:0] r_row1;
    logic [CFG_DATA_W-1:0] r_row2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_row0   <= RST_ROW0;
            r_row1   <= RST_ROW1;
            r_row2   <= RST_ROW2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                REG_COEF_ROW0:    r_row0   <= i_cfg_data;
                REG_COEF_ROW1:    r_row1   <= i_cfg_data;
                REG_COEF_ROW2:    r_row2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    always_comb begin
        if (r_width < 11'd3) begin
            w_eff = WW'(3);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height < 16'd3) ? 16'd3 : r_height;
    end

    // pipeline control
    logic r_sk_vld;
    logic adv;
    logic acc;

    assign adv           = !r_sk_vld;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;

    // position counters
    logic [CW-1:0]       r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic                col_last;
    logic                row_last;
    logic                emit;

    assign col_last = WW'(r_col) >= (w_eff - WW'(1));
    assign row_last = r_row >= (h_eff - 16'd1);
    assign emit     = (r_row >= 16'd2) && (WW'(r_col) >= WW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage 1: line buffer read data arrives
    logic          r_s1_vld;
    logic          r_s1_emit;
    logic          r_s1_last;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_emit <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= acc;
            r_s1_emit <= acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_last <= col_last && row_last;
            r_s1_pix  <= s_axis_tdata;
            r_s1_idx  <= r_col;
        end
    end

    t_pix top_pix;
    t_pix mid_pix;
    logic lb_we;

    assign lb_we = adv && r_s1_vld;

    c3cg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_pix),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (mid_pix)
    );

    c3cg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (r_s1_idx),
        .i_wdata (mid_pix),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (top_pix)
    );

    // window cells, left column is cell 0
    t_cell_ctl cell_ctl;
    t_col      cell_in  [3];
    t_col      cell_out [3];
    t_col_sum  col_sum  [3];
    t_col      new_col;

    assign cell_ctl.shift   = lb_we;
    assign cell_ctl.advance = adv;
    assign new_col          = {r_s1_pix, mid_pix, top_pix};

    for (genvar g = 0; g < 3; g++) begin : g_cell
        t_coef_col coef;

        assign coef    = {r_row2[COEF_W*g +: COEF_W], r_row1[COEF_W*g +: COEF_W],
                          r_row0[COEF_W*g +: COEF_W]};
        assign cell_in[g] = (g == 2) ? new_col : cell_out[(g == 2) ? 2 : g + 1];

        c3cg_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_pix     (cell_in[g]),
            .i_coef    (coef),
            .o_pix     (cell_out[g]),
            .o_col_sum (col_sum[g])
        );
    end

    // stages 2..4 follow the products and column sums
    logic [2:0] r_emit_pipe;
    logic [2:0] r_last_pipe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_pipe <= '0;
        end else if (adv) begin
            r_emit_pipe <= {r_emit_pipe[1:0], r_s1_emit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last_pipe <= {r_last_pipe[1:0], r_s1_last};
        end
    end

    logic signed [SUM_W-1:0] total;
    t_pix                    clamped;

    always_comb begin
        total = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
        if (total[SUM_W-1]) begin
            clamped = '0;
        end else if (|total[SUM_W-2:PIX_W]) begin
            clamped = '1;
        end else begin
            clamped = total[PIX_W-1:0];
        end
    end

    // output register with skid
    logic up_fire;
    logic r_o_vld;
    t_pix r_o_data;
    logic r_o_last;
    t_pix r_sk_data;
    logic r_sk_last;

    assign up_fire = adv && r_emit_pipe[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (!r_o_vld || m_axis_tready) begin
            r_o_vld  <= r_sk_vld || up_fire;
            r_sk_vld <= 1'b0;
        end else if (up_fire) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_vld || m_axis_tready) begin
            r_o_data <= r_sk_vld ? r_sk_data : clamped;
            r_o_last <= r_sk_vld ? r_sk_last : r_last_pipe[2];
        end else if (up_fire) begin
            r_sk_data <= clamped;
            r_sk_last <= r_last_pipe[2];
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_o_vld)
        else $error("skid holds data while output is empty");

    a_lb_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && lb_we) |-> (r_col != r_s1_idx))
        else $error("line buffer read and write hit the same column");

    a_emit_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_emit |-> r_s1_vld)
        else $error("result flagged without a pixel");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (up_fire && !r_o_vld) |=> r_o_vld)
        else $error("result lost at output register");

endmodule

// ----- dv/conv3x3_clamped_gray_unit_tb.sv -----
module conv3x3_clamped_gray_unit_tb;
    import c3cg_pkg::*;

    localparam int MAX_WIDTH     = DEF_MAX_WIDTH;
    localparam int MIN_SIDE      = 3;
    localparam int PIX_MAX       = 255;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RX_HOLD       = 300;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASE_CAP     = 300;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam t_coef EXTREME_COEF [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};

    typedef struct packed {
        t_pix filtered;
        logic last;
    } t_result;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;
    typedef enum logic [1:0] {PIX_EXTREME, PIX_DARK, PIX_ANY} t_pix_style;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   typed;
        t_result                want;
    } t_step;

    // reset coefficients are the identity mask; then the extreme mask clamps both ways
    localparam t_step DIRECTED [35] = '{
        '{ROW_CFG, REG_IMAGE_WIDTH,  48'd3, 1'b0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 48'd3, 1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd200, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b1, '{8'd200, 1'b1}},
        '{ROW_CFG, REG_IMAGE_WIDTH,  48'd0, 1'b0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 48'd1, 1'b0, '0},
        '{ROW_CFG, REG_COEF_ROW0, 48'h7FFF_7FFF_7FFF, 1'b0, '0},
        '{ROW_CFG, REG_COEF_ROW1, 48'h8000_8000_8000, 1'b0, '0},
        '{ROW_CFG, REG_COEF_ROW2, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_CFG, REG_SPARE_LAST, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b1, '{8'd0, 1'b1}},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd255, 1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b0, '0},
        '{ROW_PIX, '0, 48'd0,   1'b1, '{8'd255, 1'b1}}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    t_pix                   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor state
    logic [WIDTH_W-1:0]     width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [CFG_DATA_W-1:0]  coef_rows [3];
    t_pix                   prev_row [MAX_WIDTH];
    t_pix                   older_row [MAX_WIDTH];
    t_pix                   win [3][3];
    int unsigned            col_cnt;
    int unsigned            row_cnt;

    t_result                filtered_q [$];
    int                     bad_results = 0;
    int unsigned            rand_items = 0;
    bit                     tx_quiet = 1'b0;
    bit                     rx_quiet = 1'b0;
    bit                     rx_hold_req = 1'b0;

    conv3x3_clamped_gray_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_w(input logic [WIDTH_W-1:0] w);
        if (w < MIN_SIDE) return MIN_SIDE;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return 32'(w);
    endfunction

    function automatic int unsigned eff_h(input logic [HEIGHT_W-1:0] h);
        return (h < MIN_SIDE) ? MIN_SIDE : 32'(h);
    endfunction

    function automatic void reset_model();
        width_reg  = RST_WIDTH;
        height_reg = RST_HEIGHT;
        coef_rows  = '{RST_ROW0, RST_ROW1, RST_ROW2};
        for (int k = 0; k < MAX_WIDTH; k++) begin
            prev_row[k]  = '0;
            older_row[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
        col_cnt = 0;
        row_cnt = 0;
    endfunction

    // one pixel into the line stores and window; returns 1 when an interior result leaves
    function automatic bit convolve_pixel(input t_pix pix, output t_result res);
        int unsigned w, h, c, r, idx;
        t_pix top, mid;
        longint acc;
        w = eff_w(width_reg);
        h = eff_h(height_reg);
        c = col_cnt;
        r = row_cnt;
        idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
        top = older_row[idx];
        mid = prev_row[idx];
        older_row[idx] = mid;
        prev_row[idx]  = pix;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        res = '0;
        convolve_pixel = 1'b0;
        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    acc += longint'($signed(coef_rows[i][COEF_W*j +: COEF_W]))
                           * longint'(win[i][j]);
            if (acc > PIX_MAX) acc = PIX_MAX;
            else if (acc < 0) acc = 0;
            res.filtered = acc[PIX_W-1:0];
            res.last = (r >= h - 1) && (c >= w - 1);
            convolve_pixel = 1'b1;
        end
        if (c >= w - 1) begin
            col_cnt = 0;
            row_cnt = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    function automatic t_pix draw_pixel(input t_pix_style style);
        case (style)
            PIX_EXTREME: return $urandom_range(0, 1) ? t_pix'(PIX_MAX) : t_pix'(0);
            PIX_DARK:    return t_pix'($urandom_range(0, 15));
            default:     return t_pix'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_coef_row();
        logic [CFG_DATA_W-1:0] row;
        int mode;
        mode = $urandom_range(0, 5);
        for (int j = 0; j < 3; j++) begin
            case (mode)
                0:       row[COEF_W*j +: COEF_W] = EXTREME_COEF[$urandom_range(0, 3)];
                1:       row[COEF_W*j +: COEF_W] = t_coef'($urandom);
                default: row[COEF_W*j +: COEF_W] = t_coef'($urandom_range(0, 6)) - t_coef'(3);
            endcase
        end
        return row;
    endfunction

    task automatic flag_mismatch(input string msg);
        bad_results++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg    = value[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_reg   = value[HEIGHT_W-1:0];
            REG_COEF_ROW0:    coef_rows[0] = value;
            REG_COEF_ROW1:    coef_rows[1] = value;
            REG_COEF_ROW2:    coef_rows[2] = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pix pix, input bit use_typed, input t_result typed);
        int gap;
        t_result res;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (convolve_pixel(pix, res))
            filtered_q.push_back(use_typed ? typed : res);
    endtask

    // pixels that complete no window can still be in flight after the last result
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (filtered_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %0d last %0b",
                                        m_axis_tdata, m_axis_tlast));
            end else begin
                want = filtered_q.pop_front();
                if (m_axis_tdata !== want.filtered)
                    flag_mismatch($sformatf("filtered %0d, want %0d",
                                            m_axis_tdata, want.filtered));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("tlast %0b, want %0b",
                                            m_axis_tlast, want.last));
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int rx_gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_gap = RX_HOLD;
            end else begin
                rx_gap = rx_quiet ? 0 : $urandom_range(0, 14);
            end
            if (rx_gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        int unsigned n, frame_px, w_new;
        logic [CFG_DATA_W-1:0] value;
        t_pix_style style;
        bit at_frame_start;
        reset_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(DIRECTED); k++) begin
            if (DIRECTED[k].kind == ROW_CFG) begin
                drain_pipeline();
                write_reg(DIRECTED[k].idx, DIRECTED[k].value);
            end else begin
                send_pixel(DIRECTED[k].value[PIX_W-1:0], DIRECTED[k].typed, DIRECTED[k].want);
            end
        end

        // widest first row, then narrowed mid-frame so the frame ends early
        drain_pipeline();
        tx_quiet = 1'b1;
        value = 48'({$urandom, $urandom});
        value[WIDTH_W-1:0] = '1;
        write_reg(REG_IMAGE_WIDTH, value);
        write_reg(REG_IMAGE_HEIGHT, 48'(MIN_SIDE));
        write_reg(REG_COEF_ROW0, draw_coef_row());
        write_reg(REG_COEF_ROW1, draw_coef_row());
        write_reg(REG_COEF_ROW2, draw_coef_row());
        repeat (MAX_WIDTH + 12) send_pixel(draw_pixel(PIX_ANY), 1'b0, '0);
        drain_pipeline();
        write_reg(REG_IMAGE_WIDTH, 48'd12);
        repeat (13) send_pixel(draw_pixel(PIX_ANY), 1'b0, '0);

        // tallest height on a narrow frame while the output backs up
        drain_pipeline();
        write_reg(REG_IMAGE_WIDTH, 48'(MIN_SIDE));
        write_reg(REG_IMAGE_HEIGHT, 48'hFFFF);
        rx_hold_req = 1'b1;
        repeat (120) send_pixel(draw_pixel(PIX_ANY), 1'b0, '0);

        while (rand_items < RANDOM_ITEMS) begin
            drain_pipeline();
            at_frame_start = (col_cnt == 0) && (row_cnt == 0);
            if (eff_h(height_reg) > 64 || $urandom_range(0, 2) == 0) begin
                value = 48'({$urandom, $urandom});
                value[HEIGHT_W-1:0] = ($urandom_range(0, 7) == 0)
                                      ? HEIGHT_W'($urandom_range(0, 2))
                                      : HEIGHT_W'($urandom_range(3, 7));
                write_reg(REG_IMAGE_HEIGHT, value);
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       w_new = $urandom_range(0, 2);
                    1:       w_new = $urandom_range(11, 40);
                    default: w_new = $urandom_range(3, 10);
                endcase
                value = 48'({$urandom, $urandom});
                value[WIDTH_W-1:0] = WIDTH_W'(w_new);
                // mid-frame the line stores only hold columns of the current width
                if (at_frame_start || eff_w(WIDTH_W'(w_new)) <= eff_w(width_reg))
                    write_reg(REG_IMAGE_WIDTH, value);
            end
            for (int r = 0; r < 3; r++)
                if ($urandom_range(0, 1))
                    write_reg(REG_COEF_ROW0 + CFG_IDX_W'(r), draw_coef_row());
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_FIRST : REG_SPARE_LAST,
                          48'({$urandom, $urandom}));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)      style = PIX_EXTREME;
            else if ($urandom_range(0, 3) == 0) style = PIX_DARK;
            else                                style = PIX_ANY;
            frame_px = eff_w(width_reg) * eff_h(height_reg);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame_px)
                                             : frame_px * $urandom_range(1, 2);
            if (n > PHASE_CAP) n = PHASE_CAP;
            repeat (n) send_pixel(draw_pixel(style), 1'b0, '0);
            rand_items += n;
        end

        drain_pipeline();
        if (bad_results == 0)
            $display("conv3x3_clamped_gray_unit_tb: PASS");
        else
            $display("conv3x3_clamped_gray_unit_tb: FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("conv3x3_clamped_gray_unit_tb: FAIL");
        $finish;
    end

endmodule
